>>> rtl/cas_pkg.sv
// Shared types, constants and the cell rule of the cave automaton smoothing block.
package cas_pkg;

   localparam int CFG_W            = 11;
   localparam int CSR_INDEX_W      = 2;
   localparam int DEF_MAX_COLUMNS  = 1024;
   localparam int DEF_MAX_ROWS     = 1024;
   localparam int DEF_FRAME_SIZE   = 64;
   localparam int QUEUE_DEPTH      = 8;
   localparam int PTR_W            = $clog2(QUEUE_DEPTH);
   localparam int CNT_W            = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_ROWS    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_COLUMNS = CSR_INDEX_W'(1);

   localparam logic [3:0] WALL_THRESHOLD = 4'd5;
   localparam logic [3:0] WALL_COLUMN    = 4'b1011;

   localparam logic [CNT_W-1:0] ROOM_IDLE = CNT_W'(QUEUE_DEPTH - 2);
   localparam logic [CNT_W-1:0] ROOM_BUSY = CNT_W'(QUEUE_DEPTH - 4);

   // One line memory entry: middle row region and cell, and the row above it.
   typedef struct packed {
      logic mid_region;
      logic mid_cell;
      logic up_cell;
   } line_entry_type;

   // Position flags of a request, handed from the front stage to the evaluator.
   typedef struct packed {
      logic low;
      logic region;
      logic col_first;
      logic col_one;
      logic col_last;
      logic row_first;
      logic row_le1;
      logic row_last;
   } stage_type;

   typedef struct packed {
      logic new_cell;
      logic row_end;
      logic frame_end;
   } rsp_type;

   // A window column holds upper cell, middle cell, middle region and lower cell.
   function automatic logic [1:0] side_walls(input logic [3:0] c);
      side_walls = 2'(c[0]) + 2'(c[1]) + 2'(c[3]);
   endfunction

   function automatic logic next_cell(input logic [3:0] left, input logic [3:0] centre,
                                      input logic [3:0] right);
      logic [3:0] cnt;
      cnt = 4'(side_walls(left)) + 4'(side_walls(right)) + 4'(centre[0]) + 4'(centre[3]);
      if (!centre[2]) begin
         next_cell = centre[1];
      end else begin
         next_cell = (cnt >= WALL_THRESHOLD);
      end
   endfunction

endpackage

>>> rtl/cas_if.sv
// Request and result channel interfaces of the cave automaton smoothing block.
interface cas_req_if;
   logic valid;
   logic ready;
   logic cell_req;
   logic in_region;
   logic flush_pad;

   modport source (output valid, output cell_req, output in_region, output flush_pad,
                   input ready);
   modport sink (input valid, input cell_req, input in_region, input flush_pad,
                 output ready);
endinterface

interface cas_rsp_if;
   logic valid;
   logic ready;
   logic new_cell;
   logic row_end;
   logic frame_end;

   modport source (output valid, output new_cell, output row_end, output frame_end,
                   input ready);
   modport sink (input valid, input new_cell, input row_end, input frame_end,
                 output ready);
endinterface

>>> rtl/cas_line_mem.sv
// Line memory holding the two buffered map rows, one write and one registered read port.
module cas_line_mem
   import cas_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_COLUMNS,
   parameter int ADDR_W = $clog2(DEF_MAX_COLUMNS)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output line_entry_type      rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  line_entry_type      wr_data
);

   line_entry_type mem [DEPTH];
   line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cas_cell_eval.sv
// Window stage: forwards line data, shifts the 3x3 window and forms up to two results.
module cas_cell_eval
   import cas_pkg::*;
#(
   parameter int ADDR_W = $clog2(DEF_MAX_COLUMNS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                stage_valid,
   input  stage_type           stage,
   input  logic [ADDR_W-1:0]   stage_addr,
   input  line_entry_type      rd_data,
   output logic                wr_en,
   output logic [ADDR_W-1:0]   wr_addr,
   output line_entry_type      wr_data,
   output logic                res_a_valid,
   output rsp_type             res_a,
   output logic                res_b_valid,
   output rsp_type             res_b
);

   logic              fwd_valid_ff;
   logic              fwd_valid_in;
   logic [ADDR_W-1:0] fwd_addr_ff;
   line_entry_type    fwd_data_ff;
   logic [11:0]       win_ff;
   logic [11:0]       win_in;
   line_entry_type    entry;
   logic [3:0]        vec;
   logic [3:0]        w0;
   logic [3:0]        w1;

   // The entry written in the cycle of this read is not yet in the read data.
   always_comb begin
      entry = rd_data;
      if (fwd_valid_ff && (fwd_addr_ff == stage_addr)) begin
         entry = fwd_data_ff;
      end
   end

   always_comb begin
      vec = {stage.low, entry.mid_region, entry.mid_cell,
             stage.row_le1 ? 1'b1 : entry.up_cell};
      w0 = win_ff[7:4];
      w1 = win_ff[11:8];
      wr_en = stage_valid;
      wr_addr = stage_addr;
      wr_data = '{mid_region: stage.region, mid_cell: stage.low, up_cell: entry.mid_cell};

      res_a_valid = stage_valid && !stage.row_first && !stage.col_first;
      res_a = '{new_cell: next_cell(stage.col_one ? WALL_COLUMN : w0, w1, vec),
                row_end: 1'b0, frame_end: 1'b0};
      res_b_valid = stage_valid && !stage.row_first && stage.col_last;
      res_b = '{new_cell: next_cell(stage.col_first ? WALL_COLUMN : w1, vec, WALL_COLUMN),
                row_end: 1'b1, frame_end: stage.row_last};

      win_in = win_ff;
      fwd_valid_in = stage_valid;
      if (clear) begin
         win_in = '0;
         fwd_valid_in = 1'b0;
      end else if (stage_valid) begin
         win_in = {vec, win_ff[11:4]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         win_ff <= '0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
   end

endmodule

>>> rtl/cas_rsp_fifo.sv
// Result queue taking up to two results per cycle and giving one per cycle while rsp_chan.ready is high.
module cas_rsp_fifo
   import cas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push_a,
   input  rsp_type           data_a,
   input  logic              push_b,
   input  rsp_type           data_b,
   output logic [CNT_W-1:0]  count,
   cas_rsp_if.source         rsp_chan
);

   rsp_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  head_ff;
   logic [PTR_W-1:0]  head_in;
   logic [PTR_W-1:0]  tail_ff;
   logic [PTR_W-1:0]  tail_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              pop;
   logic [1:0]        n_push;
   rsp_type           first;

   always_comb begin
      pop = (count_ff != '0) && rsp_chan.ready;
      n_push = 2'(push_a) + 2'(push_b);
      first = push_a ? data_a : data_b;
      head_in = pop ? PTR_W'(head_ff + 1'b1) : head_ff;
      tail_in = PTR_W'(tail_ff + PTR_W'(n_push));
      count_in = CNT_W'(count_ff + CNT_W'(n_push) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entries_ff[tail_ff] <= first;
      end
      if (n_push == 2'd2) begin
         entries_ff[PTR_W'(tail_ff + 1'b1)] <= data_b;
      end
   end

   assign count = count_ff;
   assign rsp_chan.valid = (count_ff != '0);
   assign rsp_chan.new_cell = entries_ff[head_ff].new_cell;
   assign rsp_chan.row_end = entries_ff[head_ff].row_end;
   assign rsp_chan.frame_end = entries_ff[head_ff].frame_end;

endmodule

>>> rtl/cave_automaton_smoothing.sv
// Top level of the cave automaton smoothing block: position counters, request stage, wiring.
//
//   Channel    Direction  Handshake          Carries
//   req_chan   in         valid/ready        cell_req, in_region, flush_pad
//   rsp_chan   out        valid/ready        new_cell, row_end, frame_end
//   csr_*      in         csr_wr_en only     csr_index, csr_wdata
//
// One request is taken per cycle while req_chan.ready is high; the line memory is read when a request is taken and
// written back in the next cycle, one read and one write per cycle.
// A result is formed in the window stage and registered into the result queue; a row-end request
// yields two results, which the eight-entry result queue absorbs.
// req_chan.ready drops only when the queue lacks room for the requests in flight.
// Reset clears counters, window and queue; the line memory needs no clearing pass.
module cave_automaton_smoothing
   import cas_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                    clock,
   input  logic                    reset,
   cas_req_if.sink                 req_chan,
   cas_rsp_if.source               rsp_chan,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]        csr_wdata
);

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int RCMP_W = (ROW_W > CFG_W) ? ROW_W : CFG_W;
   localparam int CCMP_W = ((COL_W + 1) > CFG_W) ? (COL_W + 1) : CFG_W;
   localparam logic [ROW_W-1:0] RESET_ROWS =
      ROW_W'((DEF_FRAME_SIZE > MAX_ROWS) ? MAX_ROWS : DEF_FRAME_SIZE);
   localparam logic [COL_W-1:0] RESET_LAST_COL =
      COL_W'(((DEF_FRAME_SIZE > MAX_COLUMNS) ? MAX_COLUMNS : DEF_FRAME_SIZE) - 1);

   logic [ROW_W-1:0]  nrows_ff;
   logic [ROW_W-1:0]  nrows_in;
   logic [COL_W-1:0]  last_col_ff;
   logic [COL_W-1:0]  last_col_in;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic              stage_valid_ff;
   logic              stage_valid_in;
   stage_type         stage_ff;
   stage_type         stage_in;
   logic [COL_W-1:0]  stage_addr_ff;
   logic [RCMP_W-1:0] rows_wide;
   logic [CCMP_W-1:0] cols_wide;
   logic              cfg_hit;
   logic              req_accept;
   logic [CNT_W-1:0]  queue_count;
   line_entry_type    rd_data;
   logic              wr_en;
   logic [COL_W-1:0]  wr_addr;
   line_entry_type    wr_data;
   logic              res_a_valid;
   rsp_type           res_a;
   logic              res_b_valid;
   rsp_type           res_b;

   assign req_chan.ready = stage_valid_ff ? (queue_count <= ROOM_BUSY)
                                          : (queue_count <= ROOM_IDLE);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign cfg_hit = csr_wr_en &&
                    ((csr_index == REG_FRAME_ROWS) || (csr_index == REG_FRAME_COLUMNS));

   // Register writes are saturated to the supported frame size, and a zero to a size of one, when they are stored.
   always_comb begin
      rows_wide = RCMP_W'(csr_wdata);
      cols_wide = CCMP_W'(csr_wdata);
      nrows_in = nrows_ff;
      last_col_in = last_col_ff;
      if (csr_wr_en && (csr_index == REG_FRAME_ROWS)) begin
         if (rows_wide == '0) begin
            nrows_in = ROW_W'(1);
         end else if (rows_wide > RCMP_W'(MAX_ROWS)) begin
            nrows_in = ROW_W'(MAX_ROWS);
         end else begin
            nrows_in = ROW_W'(rows_wide);
         end
      end
      if (csr_wr_en && (csr_index == REG_FRAME_COLUMNS)) begin
         if (cols_wide == '0) begin
            last_col_in = '0;
         end else if (cols_wide > CCMP_W'(MAX_COLUMNS)) begin
            last_col_in = COL_W'(MAX_COLUMNS - 1);
         end else begin
            last_col_in = COL_W'(cols_wide - 1'b1);
         end
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_ff == last_col_ff) begin
            col_in = '0;
            row_in = (row_ff == nrows_ff) ? '0 : ROW_W'(row_ff + 1'b1);
         end else begin
            col_in = COL_W'(col_ff + 1'b1);
         end
      end
      stage_valid_in = req_accept && !cfg_hit;
      stage_in.low = (req_chan.flush_pad || (row_ff == nrows_ff)) ? 1'b1 : req_chan.cell_req;
      stage_in.region = req_chan.in_region;
      stage_in.col_first = (col_ff == '0);
      stage_in.col_one = (col_ff == COL_W'(1));
      stage_in.col_last = (col_ff == last_col_ff);
      stage_in.row_first = (row_ff == '0);
      stage_in.row_le1 = (row_ff <= ROW_W'(1));
      stage_in.row_last = (row_ff == nrows_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nrows_ff <= RESET_ROWS;
         last_col_ff <= RESET_LAST_COL;
         col_ff <= '0;
         row_ff <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         nrows_ff <= nrows_in;
         last_col_ff <= last_col_in;
         col_ff <= col_in;
         row_ff <= row_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
         stage_addr_ff <= col_ff;
      end
   end

   cas_line_mem #(
      .DEPTH  (MAX_COLUMNS),
      .ADDR_W (COL_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   cas_cell_eval #(
      .ADDR_W (COL_W)
   ) u_cell_eval (
      .clock       (clock),
      .reset       (reset),
      .clear       (cfg_hit),
      .stage_valid (stage_valid_ff),
      .stage       (stage_ff),
      .stage_addr  (stage_addr_ff),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .res_a_valid (res_a_valid),
      .res_a       (res_a),
      .res_b_valid (res_b_valid),
      .res_b       (res_b)
   );

   cas_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_a   (res_a_valid),
      .data_a   (res_a),
      .push_b   (res_b_valid),
      .data_b   (res_b),
      .count    (queue_count),
      .rsp_chan (rsp_chan)
   );

   // The result queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      queue_count <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // The position counters stay inside the configured frame plus its padding row.
   assert property (@(posedge clock) disable iff (reset)
      (col_ff <= last_col_ff) && (row_ff <= nrows_ff))
      else $error("position counter outside the frame");

   // A request taken without a register write reaches the window stage next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !cfg_hit) |=> (stage_valid_ff && (stage_addr_ff == $past(col_ff))))
      else $error("request lost between stages");

endmodule

>>> dv/cave_automaton_smoothing_tb.sv
// Self-checking testbench of the cave automaton smoothing block with a cycle-free predictor.
module cave_automaton_smoothing_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cas_pkg::*;

   localparam int MAX_COLUMNS    = DEF_MAX_COLUMNS;
   localparam int MAX_ROWS       = DEF_MAX_ROWS;
   localparam int RANDOM_CELLS   = 1860;
   localparam int STALL_LIMIT    = 4000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 20;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = CSR_INDEX_W'(3);

   typedef struct packed {
      logic wall;
      logic region;
      logic pad;
   } map_cell_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   cas_req_if req_bus();
   cas_rsp_if rsp_bus();

   cave_automaton_smoothing i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   bit [CFG_W-1:0] rows_setting = CFG_W'(DEF_FRAME_SIZE);
   bit [CFG_W-1:0] columns_setting = CFG_W'(DEF_FRAME_SIZE);
   bit [1:0] upper_row [MAX_COLUMNS];
   bit [1:0] middle_row [MAX_COLUMNS];
   bit [11:0] window_bits = '0;
   int unsigned next_column = 0;
   int unsigned next_row = 0;

   map_cell_type cell_queue[$];
   rsp_type expected_cells[$];
   rsp_type oldest;
   map_cell_type offered;
   bit req_taken = 1'b0;

   int cells_queued = 0;
   int cells_taken = 0;
   int results_seen = 0;
   int error_count = 0;
   int csr_writes = 0;
   int setups = 0;
   int random_items = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int holdoff_asks = 0;
   int holdoff_done = 0;
   int holdoff_left = 0;

   function automatic int unsigned clamp_size(bit [CFG_W-1:0] raw, int unsigned limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return raw;
   endfunction

   // A window column holds upper cell, middle cell, middle region and lower cell.
   function automatic bit smooth_cell(bit [3:0] lcol, bit [3:0] mcol, bit [3:0] rcol);
      int walls;
      walls = lcol[0] + lcol[1] + lcol[3] + rcol[0] + rcol[1] + rcol[3] + mcol[0] + mcol[3];
      if (!mcol[2]) return mcol[1];
      return walls >= WALL_THRESHOLD;
   endfunction

   task automatic predict_request(bit wall, bit region, bit pad);
      int unsigned ncols;
      int unsigned nrows;
      int unsigned col;
      int unsigned row;
      bit lower;
      bit upper;
      bit [1:0] mid;
      bit [3:0] column_bits;
      bit [3:0] left_col;
      rsp_type result;
      ncols = clamp_size(columns_setting, MAX_COLUMNS);
      nrows = clamp_size(rows_setting, MAX_ROWS);
      col = next_column;
      row = next_row;
      if (col >= ncols) col = 0;
      if (row > nrows) row = 0;
      lower = (pad || row >= nrows) ? 1'b1 : wall;
      mid = middle_row[col];
      upper = (row <= 1) ? 1'b1 : upper_row[col][0];
      column_bits = {lower, mid[1], mid[0], upper};
      upper_row[col] = mid;
      middle_row[col] = {region, lower};
      window_bits = {column_bits, window_bits[11:4]};
      if (row >= 1) begin
         if (col >= 1) begin
            left_col = (col == 1) ? WALL_COLUMN : window_bits[3:0];
            result.new_cell = smooth_cell(left_col, window_bits[7:4], window_bits[11:8]);
            result.row_end = 1'b0;
            result.frame_end = 1'b0;
            expected_cells = {expected_cells, result};
         end
         if (col == ncols - 1) begin
            left_col = (col == 0) ? WALL_COLUMN : window_bits[7:4];
            result.new_cell = smooth_cell(left_col, window_bits[11:8], WALL_COLUMN);
            result.row_end = 1'b1;
            result.frame_end = (row == nrows);
            expected_cells = {expected_cells, result};
         end
      end
      col++;
      if (col >= ncols) begin
         col = 0;
         row++;
         if (row > nrows) row = 0;
      end
      next_column = col;
      next_row = row;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 40) begin
         $display("mismatch at result %0d: %s, got %0d, expected %0d",
                  results_seen, what, got, want);
      end
   endtask

   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_request(req_bus.cell_req, req_bus.in_region, req_bus.flush_pad);
            cells_taken++;
            req_taken = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_cells.size() == 0) begin
               report_mismatch("result with no request pending", rsp_bus.new_cell, 0);
            end else begin
               oldest = expected_cells.pop_front();
               if (rsp_bus.new_cell !== oldest.new_cell)
                  report_mismatch("new_cell", rsp_bus.new_cell, oldest.new_cell);
               if (rsp_bus.row_end !== oldest.row_end)
                  report_mismatch("row_end", rsp_bus.row_end, oldest.row_end);
               if (rsp_bus.frame_end !== oldest.frame_end)
                  report_mismatch("frame_end", rsp_bus.frame_end, oldest.frame_end);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || req_taken)) begin
         if (cell_queue.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            offered = cell_queue.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.cell_req <= offered.wall;
            req_bus.in_region <= offered.region;
            req_bus.flush_pad <= offered.pad;
         end else begin
            req_bus.valid <= 1'b0;
            req_bus.cell_req <= 1'($urandom);
            req_bus.in_region <= 1'($urandom);
            req_bus.flush_pad <= 1'($urandom);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_bus.ready <= 1'b0;
      end else if (holdoff_done != holdoff_asks) begin
         holdoff_done++;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("no request or result moved for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   task automatic queue_cell(bit wall, bit region, bit pad);
      map_cell_type item;
      item.wall = wall;
      item.region = region;
      item.pad = pad;
      cell_queue = {cell_queue, item};
      cells_queued++;
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_index <= CSR_INDEX_W'($urandom);
      csr_wdata <= CFG_W'($urandom);
      csr_writes++;
      if (index == REG_FRAME_ROWS || index == REG_FRAME_COLUMNS) begin
         if (index == REG_FRAME_ROWS) begin
            rows_setting = data;
         end else begin
            columns_setting = data;
         end
         window_bits = '0;
         next_column = 0;
         next_row = 0;
      end
   endtask

   task automatic wait_idle();
      while (cells_taken != cells_queued || expected_cells.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic set_pace();
      if (random_items < 650) begin
         req_idle_pct = 11;
         rsp_idle_pct = 85;
      end else if (random_items < 1300) begin
         req_idle_pct = 85;
         rsp_idle_pct = 11;
      end else begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
   endtask

   task automatic run_frame(int wall_pct, int region_pct, bit partial, output int count);
      int unsigned nrows;
      int unsigned ncols;
      int unsigned total;
      int unsigned i;
      nrows = clamp_size(rows_setting, MAX_ROWS);
      ncols = clamp_size(columns_setting, MAX_COLUMNS);
      total = (nrows + 1) * ncols;
      count = (partial && total > 1) ? $urandom_range(total - 1, 1) : total;
      @(posedge clock);
      for (i = 0; i < count; i++) begin
         if (i / ncols == nrows) begin
            queue_cell(1'($urandom), $urandom_range(99) < region_pct, $urandom_range(99) < 80);
         end else begin
            queue_cell($urandom_range(99) < wall_pct, $urandom_range(99) < region_pct,
                       $urandom_range(99) < 3);
         end
      end
      setups++;
   endtask

   initial begin
      int count;
      int wall_pct;
      int region_pct;
      bit [1:0] pick;
      bit tall_done;
      tall_done = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cell_req = 1'b0;
      req_bus.in_region = 1'b0;
      req_bus.flush_pad = 1'b0;
      rsp_bus.ready = 1'b0;
      set_pace();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Settings left at their reset values: one row plus the start of the next.
      @(posedge clock);
      repeat (DEF_FRAME_SIZE + 3) queue_cell(1'($urandom), 1'($urandom), 1'b0);
      wait_idle();

      write_csr(REG_FRAME_ROWS, CFG_W'(2));
      write_csr(REG_FRAME_COLUMNS, CFG_W'(3));
      @(posedge clock);
      queue_cell(1, 1, 0); queue_cell(0, 1, 0); queue_cell(1, 1, 0);
      queue_cell(0, 1, 0); queue_cell(0, 0, 0); queue_cell(1, 1, 1);
      queue_cell(0, 1, 1); queue_cell(0, 1, 0); queue_cell(1, 0, 1);
      wait_idle();

      // Zero sizes fall back to a single cell.
      write_csr(REG_FRAME_ROWS, '0);
      write_csr(REG_FRAME_COLUMNS, '0);
      @(posedge clock);
      queue_cell(0, 1, 0); queue_cell(0, 1, 1);
      queue_cell(1, 0, 0); queue_cell(0, 0, 0);
      wait_idle();

      // Writes to unused indexes must leave the frame position alone.
      write_csr(REG_FRAME_ROWS, CFG_W'(1));
      write_csr(REG_FRAME_COLUMNS, CFG_W'(4));
      @(posedge clock);
      repeat (4) queue_cell(0, 1, 0);
      queue_cell(0, 1, 0);
      wait_idle();
      write_csr(REG_SPARE_LO, '1);
      write_csr(REG_SPARE_HI, '0);
      @(posedge clock);
      queue_cell(0, 1, 1); queue_cell(1, 1, 1); queue_cell(0, 0, 0);
      wait_idle();

      while (random_items < RANDOM_CELLS) begin
         set_pace();
         if (!tall_done && random_items >= 650) begin
            tall_done = 1'b1;
            write_csr(REG_FRAME_COLUMNS, '0);
            write_csr(REG_FRAME_ROWS, '1);
            run_frame($urandom_range(100), 90, 1'b0, count);
            random_items += count;
            holdoff_asks++;
         end else begin
            if ($urandom_range(9) == 0)
               write_csr($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
            pick = 2'($urandom_range(3, 1));
            if (pick[0]) write_csr(REG_FRAME_ROWS, CFG_W'($urandom_range(6)));
            if (pick[1]) write_csr(REG_FRAME_COLUMNS, CFG_W'($urandom_range(12)));
            case ($urandom_range(3))
               0: wall_pct = 0;
               1: wall_pct = 100;
               default: wall_pct = $urandom_range(100);
            endcase
            case ($urandom_range(7))
               0: region_pct = 0;
               1: region_pct = 50;
               default: region_pct = 90;
            endcase
            run_frame(wall_pct, region_pct, $urandom_range(99) < 15, count);
            random_items += count;
         end
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Ran %0d requests and checked %0d results over %0d frame setups,",
               cells_taken, results_seen, setups);
      $display("with %0d register writes, a full-height frame and %0d long stalls.",
               csr_writes, holdoff_done);
      if (error_count == 0 && expected_cells.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
